### hdl/krt_pkg.sv
// Shared types and codes for the keyed route table.
package krt_pkg;

   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 6;
   localparam int ADDR_W   = 32;
   localparam int NODE_W   = 16;
   localparam int DIST_W   = 24;

   localparam logic [OP_W-1:0] OP_INSERT      = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE      = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP_ID   = 2'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP_ADDR = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_SELF      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXISTS    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

   // Route payload held beside the key in each table row.
   typedef struct packed {
      logic [NODE_W-1:0] km_id;
      logic [ADDR_W-1:0] dest_addr;
      logic [DIST_W-1:0] distance;
      logic [ADDR_W-1:0] next_hop_addr;
      logic [NODE_W-1:0] next_hop;
   } route_type;

   localparam int ROUTE_W = $bits(route_type);

   // Outcome flags of one scan over the table.
   typedef struct packed {
      logic key_hit;
      logic free_hit;
      logic addr_hit;
   } scan_flags_type;

endpackage

### hdl/krt_ram.sv
// Generic single-port RAM with registered read data.
module krt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/krt_scan.sv
// Compare unit that inspects one table row per cycle and keeps the scan results.
module krt_scan #(
   parameter int ENTRIES = 32,
   parameter int ID_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [krt_pkg::OP_W-1:0]       op,
   input  logic [ID_BITS-1:0]             key,
   input  logic [krt_pkg::ADDR_W-1:0]     search_addr,
   input  logic                           rd_valid,
   input  logic [$clog2(ENTRIES)-1:0]     rd_idx,
   input  logic                           row_valid,
   input  logic [ID_BITS-1:0]             row_dest,
   input  krt_pkg::route_type             row_route,
   output krt_pkg::scan_flags_type        flags,
   output logic [$clog2(ENTRIES)-1:0]     key_idx,
   output logic [$clog2(ENTRIES)-1:0]     free_idx,
   output logic [ID_BITS-1:0]             sel_dest,
   output krt_pkg::route_type             sel_route
);
   import krt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   scan_flags_type   flags_ff, flags_in;
   logic [IDX_W-1:0] key_idx_ff, key_idx_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [ID_BITS-1:0] sel_dest_ff, sel_dest_in;
   route_type        sel_route_ff, sel_route_in;

   logic key_match;
   logic addr_match;
   logic key_first;
   logic addr_better;
   logic capture;

   always_comb begin
      key_match   = rd_valid && row_valid && (row_dest == key);
      addr_match  = rd_valid && row_valid && (row_route.dest_addr == search_addr);
      key_first   = key_match && !flags_ff.key_hit;
      addr_better = addr_match && (!flags_ff.addr_hit || (row_dest < sel_dest_ff));
      capture     = (op == OP_LOOKUP_ADDR) ? addr_better : key_first;

      flags_in     = flags_ff;
      key_idx_in   = key_idx_ff;
      free_idx_in  = free_idx_ff;
      sel_dest_in  = sel_dest_ff;
      sel_route_in = sel_route_ff;

      if (start) begin
         flags_in = '0;
      end else begin
         if (key_first) begin
            flags_in.key_hit = 1'b1;
            key_idx_in       = rd_idx;
         end
         if (rd_valid && !row_valid && !flags_ff.free_hit) begin
            flags_in.free_hit = 1'b1;
            free_idx_in       = rd_idx;
         end
         if (addr_match) begin
            flags_in.addr_hit = 1'b1;
         end
         if (capture) begin
            sel_dest_in  = row_dest;
            sel_route_in = row_route;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      key_idx_ff   <= key_idx_in;
      free_idx_ff  <= free_idx_in;
      sel_dest_ff  <= sel_dest_in;
      sel_route_ff <= sel_route_in;
   end

   assign flags     = flags_ff;
   assign key_idx   = key_idx_ff;
   assign free_idx  = free_idx_ff;
   assign sel_dest  = sel_dest_ff;
   assign sel_route = sel_route_ff;

endmodule

### hdl/keyed_route_table.sv
// Top level of the keyed route table: sequencer, table RAM, compare unit and result register.
// Each item runs through the scan of every RAM row, one row per cycle, then the drain and done
// states; a new item is accepted only in the idle state, after the previous result is committed.
// A finished result may wait in the output register while the next item is accepted.
// Reset is synchronous and active high; afterwards a clearing pass that writes every row
// empties the table, during which no item is accepted (configuration writes still are).
module keyed_route_table #(
   parameter int ENTRIES = 32,
   parameter int ID_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // Configuration: local node id.
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata from bit 0: dest_id[15:0], next_hop_id[31:16], next_hop_addr[63:32],
   // hop_distance[87:64], dest_addr[119:88], dest_km_id[135:120].
   input  logic [135:0] req_tdata,
   // tuser: operation[1:0].
   input  logic [1:0]   req_tuser,
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata from bit 0: found_dest_id[15:0], found_next_hop_id[31:16],
   // found_next_hop_addr[63:32], found_distance[87:64], found_dest_addr[119:88],
   // found_km_id[135:120], entry_count[141:136], zero padding[143:142].
   output logic [143:0] rsp_tdata,
   // tuser: status[2:0].
   output logic [2:0]   rsp_tuser
);
   import krt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int ROW_W = 1 + ROUTE_W + ID_BITS;

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      local_ff;

   // The item under work.
   logic [OP_W-1:0]    op_ff;
   logic [ID_BITS-1:0] key_ff;
   route_type          route_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff;
   logic [143:0]     rsp_data_ff;

   logic             accept;
   logic             out_free;
   logic             commit;

   // RAM port.
   logic             ram_we;
   logic [IDX_W-1:0] ram_addr;
   logic [ROW_W-1:0] ram_wdata;
   logic [ROW_W-1:0] ram_rdata;

   // Scan results.
   scan_flags_type     flags;
   logic [IDX_W-1:0]   key_idx;
   logic [IDX_W-1:0]   free_idx;
   logic [ID_BITS-1:0] sel_dest;
   route_type          sel_route;

   // Decision taken at the end of the scan.
   logic [2:0]         status_d;
   logic               wr_need;
   logic [IDX_W-1:0]   wr_idx;
   logic [ROW_W-1:0]   wr_row;
   logic [CNT_W-1:0]   cnt_next;
   logic               hit;
   logic [ID_BITS-1:0] req_key;
   logic [31:0]        key32;
   logic [5:0]         count_out;
   logic [15:0]        out_dest;
   route_type          out_route;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_DONE) && out_free;
   assign req_key    = ID_BITS'(req_tdata[15:0]);
   assign key32      = 32'(key_ff);

   krt_ram #(
      .WIDTH(ROW_W),
      .DEPTH(ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   krt_scan #(
      .ENTRIES(ENTRIES),
      .ID_BITS(ID_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .op         (op_ff),
      .key        (key_ff),
      .search_addr(route_ff.dest_addr),
      .rd_valid   (rd_pend_ff),
      .rd_idx     (rd_idx_ff),
      .row_valid  (ram_rdata[ROW_W-1]),
      .row_dest   (ram_rdata[ID_BITS-1:0]),
      .row_route  (route_type'(ram_rdata[ID_BITS +: ROUTE_W])),
      .flags      (flags),
      .key_idx    (key_idx),
      .free_idx   (free_idx),
      .sel_dest   (sel_dest),
      .sel_route  (sel_route)
   );

   // Outcome of the operation once every row has been inspected.
   always_comb begin
      status_d = STATUS_OK;
      wr_need  = 1'b0;
      wr_idx   = key_idx;
      wr_row   = '0;
      cnt_next = cnt_ff;
      hit      = 1'b0;
      unique case (op_ff)
         OP_INSERT: begin
            if ((key32 == 32'(local_ff)) && (route_ff.next_hop == local_ff)) begin
               status_d = STATUS_SELF;
            end else if (flags.key_hit) begin
               status_d = STATUS_EXISTS;
            end else if (!flags.free_hit) begin
               status_d = STATUS_FULL;
            end else begin
               wr_need  = 1'b1;
               wr_idx   = free_idx;
               wr_row   = {1'b1, route_ff, key_ff};
               cnt_next = cnt_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (!flags.key_hit) begin
               status_d = STATUS_NOT_FOUND;
            end else begin
               // The cleared row keeps no payload; only its valid bit matters.
               wr_need = 1'b1;
               if (cnt_ff != '0) begin
                  cnt_next = cnt_ff - CNT_W'(1);
               end
            end
         end
         OP_LOOKUP_ID: begin
            hit = flags.key_hit;
            if (!flags.key_hit) begin
               status_d = STATUS_NOT_FOUND;
            end
         end
         OP_LOOKUP_ADDR: begin
            hit = flags.addr_hit;
            if (!flags.addr_hit) begin
               status_d = STATUS_NOT_FOUND;
            end
         end
         default: begin
            status_d = STATUS_OK;
         end
      endcase
   end

   // Found fields are zero unless a lookup hit; the count saturates at its field width.
   always_comb begin
      out_dest  = hit ? 16'(sel_dest) : '0;
      out_route = hit ? sel_route : '0;
      count_out = (32'(cnt_next) > 32'd63) ? 6'd63 : 6'(cnt_next);
   end

   // RAM port sharing: clearing pass and scan use the sequencer address, the final
   // write uses the chosen slot.
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = addr_ff;
      ram_wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
         end
         ST_DONE: begin
            ram_we    = commit && wr_need;
            ram_addr  = wr_idx;
            ram_wdata = wr_row;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = addr_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
               addr_in  = '0;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               addr_in  = '0;
            end
         end
         ST_SCAN: begin
            rd_pend_in = 1'b1;
            if (addr_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (commit) begin
               state_in     = ST_IDLE;
               cnt_in       = cnt_next;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         cnt_ff       <= '0;
         local_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_pend_ff   <= rd_pend_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            local_ff <= csr_wr_data;
         end
      end
   end

   // Item and result payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      if (accept) begin
         op_ff                  <= req_tuser;
         key_ff                 <= req_key;
         route_ff.next_hop      <= req_tdata[31:16];
         route_ff.next_hop_addr <= req_tdata[63:32];
         route_ff.distance      <= req_tdata[87:64];
         route_ff.dest_addr     <= req_tdata[119:88];
         route_ff.km_id         <= req_tdata[135:120];
      end
      if (commit) begin
         rsp_status_ff <= status_d;
         rsp_data_ff   <= {2'b00, count_out, out_route.km_id, out_route.dest_addr,
                           out_route.distance, out_route.next_hop_addr,
                           out_route.next_hop, out_dest};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

### sim/testbench.sv
// Self-checking testbench for the keyed route table: directed and random requests against a mirror.
module testbench;
   import krt_pkg::*;

   localparam int ROWS             = 32;
   localparam int KEY_POOL         = 40;
   localparam int ADDR_POOL        = 6;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int RANDOM_PER_PHASE = 225;

   // One route as it travels in req_tdata and in the low bits of rsp_tdata.
   typedef struct packed {
      route_type         route;
      logic [NODE_W-1:0] dest_id;
   } route_entry_type;

   // Whole response word, laid out as rsp_tdata.
   typedef struct packed {
      logic [1:0]         pad;
      logic [COUNT_W-1:0] count;
      route_entry_type    found;
   } answer_word_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      answer_word_type     word;
   } answer_type;

   // Mirror of the route table: applies each accepted request to its own copy of the
   // rows and queues the answer the block owes for it.
   class route_table_mirror;
      logic [NODE_W-1:0] local_id;
      route_entry_type   rows[ROWS];
      bit                row_used[ROWS];
      int unsigned       used_rows;
      answer_type        awaited[$];
      int unsigned       mismatches;

      function new();
         local_id   = '0;
         used_rows  = 0;
         mismatches = 0;
         foreach (row_used[i]) row_used[i] = 1'b0;
      endfunction

      function int find_key(logic [NODE_W-1:0] key);
         int i;
         for (i = 0; i < ROWS; i++)
            if (row_used[i] && rows[i].dest_id == key)
               return i;
         return -1;
      endfunction

      function void apply_request(logic [OP_W-1:0] op, route_entry_type item);
         answer_type want;
         int         slot;
         int         hit;
         int         i;
         want.status = STATUS_OK;
         want.word   = '0;
         slot        = -1;
         hit         = -1;
         case (op)
            OP_INSERT: begin
               // Self route is refused before the key and free-row checks.
               if (item.dest_id == local_id && item.route.next_hop == local_id) begin
                  want.status = STATUS_SELF;
               end else if (find_key(item.dest_id) >= 0) begin
                  want.status = STATUS_EXISTS;
               end else begin
                  // The new route goes into the lowest free row.
                  for (i = ROWS - 1; i >= 0; i--)
                     if (!row_used[i])
                        slot = i;
                  if (slot < 0) begin
                     want.status = STATUS_FULL;
                  end else begin
                     rows[slot]     = item;
                     row_used[slot] = 1'b1;
                     used_rows++;
                  end
               end
            end
            OP_DELETE: begin
               slot = find_key(item.dest_id);
               if (slot < 0) begin
                  want.status = STATUS_NOT_FOUND;
               end else begin
                  row_used[slot] = 1'b0;
                  used_rows--;
               end
            end
            OP_LOOKUP_ID: begin
               hit = find_key(item.dest_id);
            end
            default: begin
               // Among rows with a matching address the smallest destination id wins.
               for (i = 0; i < ROWS; i++)
                  if (row_used[i] && rows[i].route.dest_addr == item.route.dest_addr &&
                      (hit < 0 || rows[i].dest_id < rows[hit].dest_id))
                     hit = i;
            end
         endcase
         if (op == OP_LOOKUP_ID || op == OP_LOOKUP_ADDR) begin
            if (hit < 0)
               want.status = STATUS_NOT_FOUND;
            else
               want.word.found = rows[hit];
         end
         want.word.count = COUNT_W'(used_rows);
         awaited.push_back(want);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_answer(logic [STATUS_W-1:0] status, logic [143:0] data);
         answer_type      want;
         answer_word_type got;
         got = data;
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual status %0h data %0h",
                     $time, status, data);
            return;
         end
         want = awaited.pop_front();
         compare("status", 32'(want.status), 32'(status));
         compare("found_dest_id", 32'(want.word.found.dest_id), 32'(got.found.dest_id));
         compare("found_next_hop_id", 32'(want.word.found.route.next_hop),
                 32'(got.found.route.next_hop));
         compare("found_next_hop_addr", want.word.found.route.next_hop_addr,
                 got.found.route.next_hop_addr);
         compare("found_distance", 32'(want.word.found.route.distance),
                 32'(got.found.route.distance));
         compare("found_dest_addr", want.word.found.route.dest_addr,
                 got.found.route.dest_addr);
         compare("found_km_id", 32'(want.word.found.route.km_id),
                 32'(got.found.route.km_id));
         compare("entry_count", 32'(want.word.count), 32'(got.count));
         compare("padding", 32'(want.word.pad), 32'(got.pad));
      endfunction
   endclass

   logic           clock       = 1'b0;
   logic           reset       = 1'b1;
   logic           csr_wr_en   = 1'b0;
   logic [15:0]    csr_wr_data = '0;
   logic           req_tvalid  = 1'b0;
   logic           req_tready;
   logic [135:0]   req_tdata   = '0;
   logic [1:0]     req_tuser   = '0;
   logic           rsp_tvalid;
   logic           rsp_tready  = 1'b0;
   logic [143:0]   rsp_tdata;
   logic [2:0]     rsp_tuser;

   route_table_mirror mirror = new();

   bit                sender_gaps      = 1'b0;
   bit                receiver_stalls  = 1'b0;
   bit                hold_off_pending = 1'b0;
   logic [NODE_W-1:0] key_pool[KEY_POOL];
   logic [ADDR_W-1:0] addr_pool[ADDR_POOL];

   keyed_route_table #(
      .ENTRIES (ROWS),
      .ID_BITS (16)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

   // Results are sampled at the edge, before any of this step's updates land.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         mirror.check_answer(rsp_tuser, rsp_tdata);
   end

   // Receiver pacing: short random stalls, and once a long hold-off so that the block
   // backs up into its request channel.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic route_entry_type make_entry(logic [15:0] dest, logic [15:0] hop,
                                                  logic [31:0] hop_addr, logic [23:0] cost,
                                                  logic [31:0] dest_addr, logic [15:0] km);
      route_entry_type e;
      e.dest_id             = dest;
      e.route.next_hop      = hop;
      e.route.next_hop_addr = hop_addr;
      e.route.distance      = cost;
      e.route.dest_addr     = dest_addr;
      e.route.km_id         = km;
      return e;
   endfunction

   // Offers one request and returns at the edge where it is taken.
   task automatic send_request(input logic [OP_W-1:0] op, input route_entry_type item);
      if (sender_gaps) begin
         while ($urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= item;
      do @(posedge clock); while (req_tready !== 1'b1);
      mirror.apply_request(op, item);
   endtask

   // The register is only written once every answer is back, so the block is idle.
   task automatic write_local_id(input logic [NODE_W-1:0] id);
      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= id;
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      mirror.local_id  = id;
      key_pool[0]      = id;
   endtask

   // Random requests over a shared pool of keys and addresses, so that keys collide,
   // the table fills and address lookups see several candidates.
   task automatic run_phase(input logic [NODE_W-1:0] id, input int unsigned insert_pct,
                            input int unsigned delete_pct, input bit gaps, input bit stalls,
                            input bit squeeze);
      route_entry_type  item;
      logic [OP_W-1:0]  op;
      int unsigned      roll;
      int unsigned      n;
      write_local_id(id);
      sender_gaps     = gaps;
      receiver_stalls = stalls;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
         if (squeeze && n == 3)
            hold_off_pending = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < insert_pct)
            op = OP_INSERT;
         else if (roll < insert_pct + delete_pct)
            op = OP_DELETE;
         else if ($urandom_range(0, 1) == 0)
            op = OP_LOOKUP_ID;
         else
            op = OP_LOOKUP_ADDR;
         item = make_entry(($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                        : key_pool[$urandom_range(0, KEY_POOL - 1)],
                           16'($urandom), $urandom, 24'($urandom),
                           ($urandom_range(0, 7) == 0) ? $urandom
                                                        : addr_pool[$urandom_range(0, ADDR_POOL - 1)],
                           16'($urandom));
         if ($urandom_range(0, 15) == 0)
            item.route.next_hop = id;
         if (op == OP_INSERT && $urandom_range(0, 15) == 0) begin
            item.dest_id        = id;
            item.route.next_hop = id;
         end
         send_request(op, item);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      foreach (key_pool[i]) key_pool[i] = 16'($urandom);
      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      key_pool[1]  = 16'h0000;
      key_pool[2]  = 16'hFFFF;
      addr_pool[0] = 32'h0000_0000;
      addr_pool[1] = 32'hFFFF_FFFF;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the local id still at its reset value of zero.
      send_request(OP_LOOKUP_ID, make_entry(16'h0000, '0, '0, '0, '0, '0));
      send_request(OP_LOOKUP_ADDR, make_entry(16'h0000, '0, '0, '0, 32'h0, '0));
      send_request(OP_DELETE, make_entry(16'h0000, '0, '0, '0, '0, '0));
      // A route to and via this node is refused.
      send_request(OP_INSERT, make_entry(16'h0000, 16'h0000, 32'h1, 24'h1, 32'h1, 16'h1));
      send_request(OP_INSERT, make_entry(16'h0000, 16'h0001, '0, '0, '0, '0));
      send_request(OP_INSERT, make_entry(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF,
                                         32'hFFFF_FFFF, 16'hFFFF));
      send_request(OP_INSERT, make_entry(16'h0000, 16'h0002, 32'h5, 24'h5, 32'h5, 16'h5));
      send_request(OP_INSERT, make_entry(16'h00FF, 16'h0000, 32'hA5A5_5A5A, 24'h5A_A55A,
                                         32'hFFFF_FFFF, 16'h5AA5));
      send_request(OP_LOOKUP_ADDR, make_entry(16'h0000, '0, '0, '0, 32'hFFFF_FFFF, '0));
      send_request(OP_LOOKUP_ID, make_entry(16'hFFFF, '0, '0, '0, '0, '0));
      send_request(OP_LOOKUP_ID, make_entry(16'h0000, '0, '0, '0, '0, '0));
      send_request(OP_LOOKUP_ADDR, make_entry(16'h0000, '0, '0, '0, 32'h0, '0));
      send_request(OP_DELETE, make_entry(16'h00FF, '0, '0, '0, '0, '0));
      send_request(OP_LOOKUP_ADDR, make_entry(16'h0000, '0, '0, '0, 32'hFFFF_FFFF, '0));
      send_request(OP_DELETE, make_entry(16'h00FF, '0, '0, '0, '0, '0));
      send_request(OP_LOOKUP_ID, make_entry(16'h00FF, '0, '0, '0, '0, '0));
      req_tvalid <= 1'b0;

      // Fill, drain and mixed phases under different local ids; the last has no idling.
      run_phase(16'hFFFF, 70, 10, 1'b1, 1'b1, 1'b1);
      run_phase(16'($urandom), 20, 55, 1'b1, 1'b0, 1'b0);
      run_phase(16'h0001, 40, 30, 1'b0, 1'b1, 1'b0);
      run_phase(16'h8000, 70, 10, 1'b1, 1'b1, 1'b0);
      run_phase(16'($urandom), 15, 60, 1'b1, 1'b1, 1'b0);
      run_phase(16'h0000, 45, 30, 1'b0, 1'b0, 1'b0);

      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (ROWS + 8) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.awaited.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### filelist.f
hdl/krt_pkg.sv
hdl/krt_ram.sv
hdl/krt_scan.sv
hdl/keyed_route_table.sv
sim/testbench.sv
